### sv/iads_pkg.sv
// Shared types and constants for the indexed array engine.
// Used by iads_cell, iads_or_tree and indexed_array_insert_delete_search.
`default_nettype none

package iads_pkg;

  localparam int DEPTH   = 64;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int POS_W   = 7;
  localparam int VAL_W   = 32;
  localparam int CMP_W   = (POS_W > CNT_W) ? POS_W : CNT_W;
  localparam int GROUP   = 8;
  localparam int NGROUP  = (DEPTH + GROUP - 1) / GROUP;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_SEARCH = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // Broadcast to every cell in the row.
  typedef struct packed {
    logic                    ins;
    logic                    del;
    logic                    srch;
    logic [CMP_W-1:0]        pos;
    logic [CMP_W-1:0]        count;
    logic signed [VAL_W-1:0] value;
  } cell_ctl_t;

endpackage

`default_nettype wire

### sv/iads_cell.sv
// One slot of the shifting table: holds an entry, shifts from a neighbor
// and compares against the broadcast search value. Depends on iads_pkg.
`default_nettype none

module iads_cell (
  input  logic                             clk,
  input  logic [iads_pkg::IDX_W-1:0]       cell_index,
  input  iads_pkg::cell_ctl_t              ctl,
  input  logic signed [iads_pkg::VAL_W-1:0] prev_entry,
  input  logic signed [iads_pkg::VAL_W-1:0] next_entry,
  output logic signed [iads_pkg::VAL_W-1:0] entry,
  output logic                             match
);

  logic [iads_pkg::CMP_W-1:0] idx;

  assign idx = iads_pkg::CMP_W'(cell_index);

  always_ff @(posedge clk) begin
    if (ctl.ins && (idx > ctl.pos)) begin
      entry <= prev_entry;
    end else if (ctl.ins && (idx == ctl.pos)) begin
      entry <= ctl.value;
    end else if (ctl.del && (idx >= ctl.pos)) begin
      entry <= next_entry;
    end
  end

  // Only slots below the count take part in a search.
  always_ff @(posedge clk) begin
    match <= ctl.srch && (idx < ctl.count) && (entry == ctl.value);
  end

endmodule

`default_nettype wire

### sv/iads_or_tree.sv
// Registered OR reduction of the per-cell match bits.
// Depends on iads_pkg.
`default_nettype none

module iads_or_tree (
  input  logic                      clk,
  input  logic [iads_pkg::DEPTH-1:0] match_bits,
  output logic                      hit
);

  localparam int PAD_W = iads_pkg::NGROUP * iads_pkg::GROUP;

  logic [PAD_W-1:0]               padded;
  logic [iads_pkg::NGROUP-1:0]    group_hit;

  assign padded = PAD_W'(match_bits);

  // Hold one OR per group of cells.
  always_ff @(posedge clk) begin
    for (int g = 0; g < iads_pkg::NGROUP; g++) begin
      group_hit[g] <= |padded[g*iads_pkg::GROUP +: iads_pkg::GROUP];
    end
  end

  assign hit = |group_hit;

endmodule

`default_nettype wire

### sv/indexed_array_insert_delete_search.sv
// Ordered table of up to DEPTH signed 32-bit entries held in a row of cells.
// One operation (insert, delete or search) is accepted every clock cycle and
// busy stays low; each result appears on strobe after passing the match
// register in each cell and the registered OR tree over the row. Results
// arrive in order and cannot be held.
// Depends on iads_pkg, iads_cell and iads_or_tree.
`default_nettype none

module indexed_array_insert_delete_search (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       mode,
  input  logic [iads_pkg::POS_W-1:0]       position,
  input  logic signed [iads_pkg::VAL_W-1:0] item_value,
  output logic                             strobe,
  output logic                             found,
  output logic [1:0]                       status,
  output logic [iads_pkg::CNT_W-1:0]       count_after
);

  localparam int DEPTH = iads_pkg::DEPTH;

  logic [iads_pkg::CNT_W-1:0]       count;
  logic [iads_pkg::CNT_W-1:0]       count_next;
  iads_pkg::status_t                st_next;
  iads_pkg::cell_ctl_t              ctl;
  logic [iads_pkg::CMP_W-1:0]       pos_x;
  logic [iads_pkg::CMP_W-1:0]       cnt_x;
  logic                             accept;

  logic                             v1;
  logic                             v2;
  iads_pkg::status_t                st1;
  iads_pkg::status_t                st2;
  logic [iads_pkg::CNT_W-1:0]       cnt1;
  logic [iads_pkg::CNT_W-1:0]       cnt2;

  logic signed [iads_pkg::VAL_W-1:0] entry_w [DEPTH];
  logic [DEPTH-1:0]                 match_bits;
  logic                             hit;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign pos_x  = iads_pkg::CMP_W'(position);
  assign cnt_x  = iads_pkg::CMP_W'(count);

  // Decode the operation against the current count.
  always_comb begin
    count_next = count;
    st_next    = iads_pkg::ST_DONE;
    ctl.ins    = 1'b0;
    ctl.del    = 1'b0;
    ctl.srch   = 1'b0;
    ctl.pos    = pos_x;
    ctl.count  = cnt_x;
    ctl.value  = item_value;
    unique case (mode)
      iads_pkg::MODE_INSERT: begin
        if (count == iads_pkg::CNT_W'(DEPTH)) begin
          st_next = iads_pkg::ST_FULL;
        end else if (pos_x > cnt_x) begin
          st_next = iads_pkg::ST_RANGE;
        end else begin
          ctl.ins    = accept;
          count_next = count + 1'b1;
        end
      end
      iads_pkg::MODE_DELETE: begin
        if (pos_x >= cnt_x) begin
          st_next = iads_pkg::ST_RANGE;
        end else begin
          ctl.del    = accept;
          count_next = count - 1'b1;
        end
      end
      iads_pkg::MODE_SEARCH: begin
        ctl.srch = accept;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      v1    <= 1'b0;
      v2    <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
      end
      v1 <= accept;
      v2 <= v1;
    end
  end

  // Status and count travel alongside the match tree.
  always_ff @(posedge clk) begin
    st1  <= st_next;
    cnt1 <= count_next;
    st2  <= st1;
    cnt2 <= cnt1;
  end

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [iads_pkg::VAL_W-1:0] prev_e;
      logic signed [iads_pkg::VAL_W-1:0] next_e;
      if (i == 0) begin : g_first
        assign prev_e = item_value;
      end else begin : g_prev
        assign prev_e = entry_w[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
        assign next_e = entry_w[i];
      end else begin : g_next
        assign next_e = entry_w[i+1];
      end
      iads_cell u_cell (
        .clk        (clk),
        .cell_index (iads_pkg::IDX_W'(i)),
        .ctl        (ctl),
        .prev_entry (prev_e),
        .next_entry (next_e),
        .entry      (entry_w[i]),
        .match      (match_bits[i])
      );
    end
  endgenerate

  iads_or_tree u_tree (
    .clk        (clk),
    .match_bits (match_bits),
    .hit        (hit)
  );

  assign strobe      = v2;
  assign found       = hit;
  assign status      = st2;
  assign count_after = cnt2;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= iads_pkg::CNT_W'(DEPTH))
    else $error("entry count above table depth");

  a_strobe_origin: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(start, 2))
    else $error("result beat without an accepted operation");

  a_found_done: assert property (@(posedge clk) disable iff (rst)
    (strobe && found) |-> (status == iads_pkg::ST_DONE))
    else $error("hit reported with a refusal status");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (strobe && status == iads_pkg::ST_FULL) |-> (count_after == iads_pkg::CNT_W'(DEPTH)))
    else $error("full refusal with table not full");
`endif

endmodule

`default_nettype wire
